[rtl/core/tbs_pkg.sv]
package tbs_pkg;

   // table geometry
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // field and register widths
   localparam int SAMPLE_W   = 16;
   localparam int RADIUS_W   = 5;
   localparam int PASS_W     = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 5;

   // register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PASS_COUNT = 1'd1;
   localparam logic [RADIUS_W-1:0]  RADIUS_RESET   = 5'd1;
   localparam logic [PASS_W-1:0]    PASS_RESET     = 4'd1;

   // sweep arithmetic
   localparam int SUM_W       = 22;
   localparam int STEP_W      = 7;
   localparam int IDX_W       = 9;
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_W     = 28;
   localparam int PROD_W      = SUM_W + RECIP_W;

   // largest quotient magnitude, reached only by a negative average
   localparam logic [SAMPLE_W-1:0] Q_LIMIT = 16'h8000;

   // ceil(2^27 / (2*radius + 1)) for every radius
   localparam logic [RECIP_W-1:0] RECIP_TABLE [0:31] = '{
      28'd134217728, 28'd44739243, 28'd26843546, 28'd19173962,
      28'd14913081,  28'd12201612, 28'd10324441, 28'd8947849,
      28'd7895161,   28'd7064091,  28'd6391321,  28'd5835554,
      28'd5368710,   28'd4971027,  28'd4628198,  28'd4329605,
      28'd4067204,   28'd3834793,  28'd3627507,  28'd3441481,
      28'd3273604,   28'd3121343,  28'd2982617,  28'd2855697,
      28'd2739138,   28'd2631721,  28'd2532410,  28'd2440323,
      28'd2354697,   28'd2274877,  28'd2200291,  28'd2130441
   };

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] smoothed;
      logic                       last_out;
      logic                       overflow;
   } rsp_type;

   // one step of a smoothing sweep
   typedef struct packed {
      logic              valid;
      logic              clear;
      logic              sub_en;
      logic              out_en;
      logic [ADDR_W-1:0] out_addr;
   } step_type;

   // write of one averaged entry
   typedef struct packed {
      logic                we;
      logic [ADDR_W-1:0]   addr;
      logic [SAMPLE_W-1:0] data;
   } wr_type;

endpackage

[rtl/core/table_box_smooth.sv]
// Loads a table of up to 64 signed samples, one request a cycle while in the
// load state (req_stall is high in all others), the last one flagged by
// last_in; samples beyond 64 are dropped and reported through overflow on
// every result of that table. After the last sample the table is smoothed
// pass_count times by a centered moving average of 2*radius+1 entries (ends
// replicated, rounded to nearest), ping-ponging between two dual-read
// memories. Each pass sweeps the memory reads, then drains the sum/divide
// pipeline. Results then stream out one at a time: a result read is issued
// only after the previous one has reached the output register. New requests
// are taken as soon as the last result sits in the output register.
module table_box_smooth (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  tbs_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output tbs_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [tbs_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tbs_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tbs_pkg::*;

   localparam logic [1:0] ST_LOAD  = 2'd0;
   localparam logic [1:0] ST_PASS  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [RADIUS_W-1:0] radius_ff, radius_in;
   logic [PASS_W-1:0]   pass_count_ff, pass_count_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                dropped_ff, dropped_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PASS_W-1:0]   pass_ff, pass_in;
   logic                bank_ff, bank_in;
   logic [CNT_W-1:0]    emit_ff, emit_in;
   logic                rd_pend_ff, rd_pend_in;
   logic                pend_last_ff, pend_last_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic                req_acc;
   logic                full;
   logic                emit_issue;
   logic                last_step;
   logic [ADDR_W-1:0]   n_last;
   logic signed [IDX_W-1:0] s_idx, r_idx, two_r, a_idx, b_idx, end_idx;
   logic [ADDR_W-1:0]   addr_a, addr_b;
   step_type            step;
   wr_type              avg_wr;
   logic                avg_busy;

   logic                ram0_we, ram1_we;
   logic [ADDR_W-1:0]   ram0_waddr;
   logic [SAMPLE_W-1:0] ram0_wdata;
   logic [ADDR_W-1:0]   rd_addr_a;
   logic [SAMPLE_W-1:0] ram0_a, ram0_b, ram1_a, ram1_b;
   logic [SAMPLE_W-1:0] src_a, src_b;

   function automatic logic [ADDR_W-1:0] clamp_idx(
      input logic signed [IDX_W-1:0] v,
      input logic [ADDR_W-1:0]       hi
   );
      logic signed [IDX_W-1:0] hi_s;
      hi_s = $signed(IDX_W'(hi));
      if (v < 0) begin
         return '0;
      end else if (v > hi_s) begin
         return hi;
      end
      return v[ADDR_W-1:0];
   endfunction

   // register writes
   always_comb begin
      radius_in     = radius_ff;
      pass_count_in = pass_count_ff;
      if (csr_we) begin
         case (csr_index)
            REG_RADIUS:     radius_in     = csr_wdata[RADIUS_W-1:0];
            REG_PASS_COUNT: pass_count_in = csr_wdata[PASS_W-1:0];
            default:        ;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign req_acc   = req_valid & ~req_stall;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign n_last    = ADDR_W'(count_ff - 1'b1);

   // sweep step s adds entry s-r, drops entry s-3r-1, finishes center s-2r
   always_comb begin
      s_idx   = $signed(IDX_W'(step_ff));
      r_idx   = $signed(IDX_W'(radius_ff));
      two_r   = r_idx + r_idx;
      a_idx   = s_idx - r_idx;
      b_idx   = s_idx - two_r - r_idx - IDX_W'(1);
      end_idx = two_r + $signed(IDX_W'(count_ff)) - IDX_W'(1);
      addr_a  = clamp_idx(a_idx, n_last);
      addr_b  = clamp_idx(b_idx, n_last);
      last_step     = (s_idx == end_idx);
      step.valid    = (state_ff == ST_PASS);
      step.clear    = (step_ff == '0);
      step.sub_en   = (s_idx > two_r);
      step.out_en   = (s_idx >= two_r);
      step.out_addr = ADDR_W'(s_idx - two_r);
   end

   // a result read is issued only when the output register will be free
   assign emit_issue = (state_ff == ST_EMIT) & ~rd_pend_ff & (emit_ff < count_ff)
                     & (~rsp_valid_ff | ~rsp_stall);

   assign src_a = bank_ff ? ram1_a : ram0_a;
   assign src_b = bank_ff ? ram1_b : ram0_b;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      step_in      = step_ff;
      pass_in      = pass_ff;
      bank_in      = bank_ff;
      emit_in      = emit_ff;
      rd_pend_in   = 1'b0;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_acc) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (req_data.last_in) begin
                  step_in  = '0;
                  pass_in  = '0;
                  emit_in  = '0;
                  state_in = (pass_count_ff == '0) ? ST_EMIT : ST_PASS;
               end
            end
         end
         ST_PASS: begin
            step_in = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!avg_busy) begin
               bank_in = ~bank_ff;
               step_in = '0;
               pass_in = PASS_W'(pass_ff + 1'b1);
               if (PASS_W'(pass_ff + 1'b1) == pass_count_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_PASS;
               end
            end
         end
         ST_EMIT: begin
            if (emit_issue) begin
               emit_in      = emit_ff + 1'b1;
               rd_pend_in   = 1'b1;
               pend_last_in = (emit_ff == (count_ff - 1'b1));
            end
            if (rd_pend_ff) begin
               rsp_valid_in    = 1'b1;
               rsp_in.smoothed = $signed(src_a);
               rsp_in.last_out = pend_last_ff;
               rsp_in.overflow = dropped_ff;
               if (pend_last_ff) begin
                  state_in   = ST_LOAD;
                  count_in   = '0;
                  dropped_in = 1'b0;
                  bank_in    = 1'b0;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         radius_ff     <= RADIUS_RESET;
         pass_count_ff <= PASS_RESET;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         step_ff       <= '0;
         pass_ff       <= '0;
         bank_ff       <= 1'b0;
         emit_ff       <= '0;
         rd_pend_ff    <= 1'b0;
         pend_last_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radius_ff     <= radius_in;
         pass_count_ff <= pass_count_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         step_ff       <= step_in;
         pass_ff       <= pass_in;
         bank_ff       <= bank_in;
         emit_ff       <= emit_in;
         rd_pend_ff    <= rd_pend_in;
         pend_last_ff  <= pend_last_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   // memory ports: bank 0 takes the loaded table, each pass writes the other bank
   assign ram0_we    = (req_acc & ~full) | (avg_wr.we & bank_ff);
   assign ram0_waddr = (state_ff == ST_LOAD) ? count_ff[ADDR_W-1:0] : avg_wr.addr;
   assign ram0_wdata = (state_ff == ST_LOAD) ? req_data.sample : avg_wr.data;
   assign ram1_we    = avg_wr.we & ~bank_ff;
   assign rd_addr_a  = (state_ff == ST_EMIT) ? emit_ff[ADDR_W-1:0] : addr_a;

   tbs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_sample_store (
      .clock   (clock),
      .we      (ram0_we),
      .waddr   (ram0_waddr),
      .wdata   (ram0_wdata),
      .raddr_a (rd_addr_a),
      .raddr_b (addr_b),
      .rdata_a (ram0_a),
      .rdata_b (ram0_b)
   );

   tbs_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_scratch_store (
      .clock   (clock),
      .we      (ram1_we),
      .waddr   (avg_wr.addr),
      .wdata   (avg_wr.data),
      .raddr_a (rd_addr_a),
      .raddr_b (addr_b),
      .rdata_a (ram1_a),
      .rdata_b (ram1_b)
   );

   tbs_avg u_avg (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .radius   (radius_ff),
      .add_data (src_a),
      .sub_data (src_b),
      .busy     (avg_busy),
      .wr       (avg_wr)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_wr_in_pass: assert property (@(posedge clock) disable iff (reset)
      avg_wr.we |-> (state_ff == ST_PASS || state_ff == ST_DRAIN))
      else $error("averaged write outside a smoothing pass");

   a_pend_in_emit: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_EMIT))
      else $error("result read pending outside emission");

   a_table_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PASS || state_ff == ST_EMIT) |-> (count_ff != '0))
      else $error("smoothing or emitting an empty table");

endmodule

[rtl/core/tbs_ram.sv]
module tbs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem [0:DEPTH-1];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a_ff <= mem[raddr_a];
      rdata_b_ff <= mem[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

[rtl/core/tbs_avg.sv]
module tbs_avg (
   input  logic                             clock,
   input  logic                             reset,
   input  tbs_pkg::step_type                step,
   input  logic [tbs_pkg::RADIUS_W-1:0]     radius,
   input  logic [tbs_pkg::SAMPLE_W-1:0]     add_data,
   input  logic [tbs_pkg::SAMPLE_W-1:0]     sub_data,
   output logic                             busy,
   output tbs_pkg::wr_type                  wr
);
   import tbs_pkg::*;

   step_type                   ctl1_ff, ctl2_ff, ctl3_ff, ctl4_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]           abs_val;
   logic [SUM_W-1:0]           mag_ff, mag_in;
   logic                       neg_ff, neg3_ff;
   logic [RECIP_W-1:0]         recip_ff, recip_in;
   logic [PROD_W-1:0]          prod_ff, prod_in;
   logic [SAMPLE_W-1:0]        quot;

   // step control follows the data down the pipe
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         ctl4_ff <= '0;
      end else begin
         ctl1_ff <= step;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         ctl4_ff <= ctl3_ff;
      end
   end

   // window sum: add the entering sample, drop the leaving one
   always_comb begin
      sum_in = sum_ff;
      if (ctl1_ff.valid) begin
         sum_in = (ctl1_ff.clear ? '0 : sum_ff)
                + SUM_W'($signed(add_data))
                - (ctl1_ff.sub_en ? SUM_W'($signed(sub_data)) : '0);
      end
   end

   // magnitude plus half the window length for rounding
   assign abs_val  = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   assign mag_in   = abs_val + SUM_W'(radius);
   assign recip_in = RECIP_TABLE[radius];

   // divide by the window length through its reciprocal
   assign prod_in = mag_ff * recip_ff;
   assign quot    = prod_ff[RECIP_SHIFT +: SAMPLE_W];

   always_ff @(posedge clock) begin
      sum_ff   <= reset ? '0 : sum_in;
      mag_ff   <= mag_in;
      neg_ff   <= sum_ff[SUM_W-1];
      recip_ff <= recip_in;
      prod_ff  <= prod_in;
      neg3_ff  <= neg_ff;
   end

   // restore the sign and write the averaged entry
   always_comb begin
      wr.we   = ctl4_ff.valid & ctl4_ff.out_en;
      wr.addr = ctl4_ff.out_addr;
      wr.data = neg3_ff ? SAMPLE_W'(-quot) : quot;
   end

   assign busy = ctl1_ff.valid | ctl2_ff.valid | ctl3_ff.valid | ctl4_ff.valid;

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      wr.we |-> (quot <= Q_LIMIT))
      else $error("averaged magnitude beyond sample range");

   a_pos_fits: assert property (@(posedge clock) disable iff (reset)
      (wr.we && !neg3_ff) |-> !quot[SAMPLE_W-1])
      else $error("positive average does not fit the sample field");

endmodule
